// File: src/jts_pkg.sv
// Shared types, constants and lookup functions for the JSON token scanner.
// Used by jts_result_fifo and json_token_scanner; depends on nothing else.
package jts_pkg;

    localparam int NumberWidth = 32;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int TdataWidth  = 48;

    typedef enum logic [3:0] {
        TK_OBJ_START = 4'd0,
        TK_OBJ_END   = 4'd1,
        TK_ARR_START = 4'd2,
        TK_ARR_END   = 4'd3,
        TK_COLON     = 4'd4,
        TK_COMMA     = 4'd5,
        TK_TRUE      = 4'd6,
        TK_FALSE     = 4'd7,
        TK_NULL      = 4'd8,
        TK_STR_BYTE  = 4'd9,
        TK_STR_END   = 4'd10,
        TK_NUMBER    = 4'd11,
        TK_EOF       = 4'd12,
        TK_ERROR     = 4'd13
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_LITERAL = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_ERROR   = 3'd4
    } scan_mode_t;

    localparam logic [1:0] WORD_TRUE  = 2'd0;
    localparam logic [1:0] WORD_FALSE = 2'd1;
    localparam logic [1:0] WORD_NULL  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;

    typedef struct packed {
        token_kind_t        kind;
        logic [7:0]         char_value;
        logic signed [31:0] number_value;
        logic               last;
    } jts_result_t;

    function automatic logic [7:0] word_letter(input logic [1:0] word, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        case (word)
            WORD_TRUE: begin
                case (idx)
                    3'd0: ch = 8'h74;
                    3'd1: ch = 8'h72;
                    3'd2: ch = 8'h75;
                    3'd3: ch = 8'h65;
                    default: ch = CH_NUL;
                endcase
            end
            WORD_FALSE: begin
                case (idx)
                    3'd0: ch = 8'h66;
                    3'd1: ch = 8'h61;
                    3'd2: ch = 8'h6C;
                    3'd3: ch = 8'h73;
                    3'd4: ch = 8'h65;
                    default: ch = CH_NUL;
                endcase
            end
            WORD_NULL: begin
                case (idx)
                    3'd0: ch = 8'h6E;
                    3'd1: ch = 8'h75;
                    3'd2: ch = 8'h6C;
                    3'd3: ch = 8'h6C;
                    default: ch = CH_NUL;
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] word_length(input logic [1:0] word);
        logic [2:0] len;
        case (word)
            WORD_TRUE:  len = 3'd4;
            WORD_FALSE: len = 3'd5;
            WORD_NULL:  len = 3'd4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

// File: src/json_token_scanner.sv
// Streaming JSON token scanner: one document byte in, up to two tokens out.
// The tokens of a byte are written into the result queue as the byte is taken.
// Throughput: one byte per cycle while the result queue has room; a number followed by a
// token-producing byte puts two tokens out, which leave the result side one at a time.
// The byte input pauses while the four-entry result queue has fewer than two free slots.
// Reset clears the scanner to idle between tokens and empties the result queue.
module json_token_scanner (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] in_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jts_pkg::TdataWidth-1:0]    m_tdata,  // [3:0] token_kind,
                                                        // [11:4] char_value,
                                                        // [43:12] number_value, rest zero
    output logic                              m_tlast   // last_of_item
);
    import jts_pkg::*;

    scan_mode_t              mode_reg, mode_next;
    logic [1:0]              word_reg, word_next;
    logic [2:0]              index_reg, index_next;
    logic [NumberWidth-1:0]  mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic                    frozen_reg, frozen_next;
    logic                    started_reg, started_next;

    logic [7:0]              c;
    logic                    accept;
    logic                    is_digit, is_num;

    // Idle scan of the current byte.
    logic                    idle_hit;
    token_kind_t             idle_kind;
    scan_mode_t              idle_mode;
    logic                    idle_lit;
    logic [1:0]              idle_word;

    // Number accumulation from a base state.
    logic [NumberWidth-1:0]  base_mag;
    logic                    base_neg, base_frozen, base_started;
    logic [NumberWidth-1:0]  take_mag;
    logic                    take_neg, take_frozen;
    logic [NumberWidth+3:0]  scaled;
    logic [NumberWidth-1:0]  num_limit;
    logic signed [NumberWidth-1:0] num_result;

    logic [2:0]              idx_plus1;
    logic                    r0_valid, r1_valid;
    jts_result_t             r0, r1, head;
    logic                    room_for_two;

    assign c        = s_tdata;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = room_for_two;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_num   = is_digit || (c == CH_MINUS);
    assign idx_plus1 = index_reg + 3'd1;

    always_comb begin
        idle_hit  = 1'b1;
        idle_kind = TK_ERROR;
        idle_mode = MODE_IDLE;
        idle_lit  = 1'b0;
        idle_word = WORD_TRUE;
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_CR: idle_hit = 1'b0;
            CH_LBRACE: idle_kind = TK_OBJ_START;
            CH_RBRACE: idle_kind = TK_OBJ_END;
            CH_LBRACK: idle_kind = TK_ARR_START;
            CH_RBRACK: idle_kind = TK_ARR_END;
            CH_COLON:  idle_kind = TK_COLON;
            CH_COMMA:  idle_kind = TK_COMMA;
            CH_NUL:    idle_kind = TK_EOF;
            CH_QUOTE: begin
                idle_hit  = 1'b0;
                idle_mode = MODE_STRING;
            end
            CH_T, CH_F, CH_N: begin
                idle_hit  = 1'b0;
                idle_mode = MODE_LITERAL;
                idle_lit  = 1'b1;
                idle_word = (c == CH_T) ? WORD_TRUE : (c == CH_F) ? WORD_FALSE : WORD_NULL;
            end
            default: begin
                if (is_num) begin
                    idle_hit  = 1'b0;
                    idle_mode = MODE_NUMBER;
                end else begin
                    idle_mode = MODE_ERROR;
                end
            end
        endcase
    end

    // A number that starts in idle accumulates from a cleared state.
    always_comb begin
        num_limit = {1'b1, {(NumberWidth-1){1'b0}}};
        if (mode_reg == MODE_IDLE) begin
            base_mag     = '0;
            base_neg     = 1'b0;
            base_frozen  = 1'b0;
            base_started = 1'b0;
        end else begin
            base_mag     = mag_reg;
            base_neg     = neg_reg;
            base_frozen  = frozen_reg;
            base_started = started_reg;
        end
        scaled = {1'b0, base_mag, 3'b000} + {3'b000, base_mag, 1'b0}
               + (NumberWidth+4)'(c[3:0]);
        take_mag    = base_mag;
        take_neg    = base_neg;
        take_frozen = base_frozen;
        if (c == CH_MINUS) begin
            if (!base_started) begin
                take_neg = 1'b1;
            end else begin
                take_frozen = 1'b1;
            end
        end else if (!base_frozen) begin
            if (scaled > (NumberWidth+4)'(num_limit)) begin
                take_mag = num_limit;
            end else begin
                take_mag = scaled[NumberWidth-1:0];
            end
        end
        if (neg_reg) begin
            num_result = NumberWidth'(-$signed(mag_reg));
        end else if (mag_reg >= num_limit) begin
            num_result = $signed(num_limit - 1'b1);
        end else begin
            num_result = $signed(mag_reg);
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        word_next    = word_reg;
        index_next   = index_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        frozen_next  = frozen_reg;
        started_next = started_reg;
        r0_valid     = 1'b0;
        r1_valid     = 1'b0;
        r0           = '{kind: TK_ERROR, char_value: 8'd0, number_value: 32'sd0, last: 1'b1};
        r1           = '{kind: TK_ERROR, char_value: 8'd0, number_value: 32'sd0, last: 1'b1};
        case (mode_reg)
            MODE_IDLE: begin
                r0_valid  = idle_hit;
                r0.kind   = idle_kind;
                mode_next = idle_mode;
                if (idle_lit) begin
                    word_next  = idle_word;
                    index_next = 3'd1;
                end
                if (idle_mode == MODE_NUMBER) begin
                    mag_next     = take_mag;
                    neg_next     = take_neg;
                    frozen_next  = take_frozen;
                    started_next = 1'b1;
                end
            end
            MODE_STRING: begin
                r0_valid = 1'b1;
                if (c == CH_QUOTE) begin
                    r0.kind   = TK_STR_END;
                    mode_next = MODE_IDLE;
                end else if (c == CH_NUL) begin
                    r0.kind   = TK_ERROR;
                    mode_next = MODE_ERROR;
                end else begin
                    r0.kind       = TK_STR_BYTE;
                    r0.char_value = c;
                end
            end
            MODE_LITERAL: begin
                if ((index_reg < word_length(word_reg)) &&
                    (word_letter(word_reg, index_reg) == c)) begin
                    if (idx_plus1 == word_length(word_reg)) begin
                        r0_valid   = 1'b1;
                        r0.kind    = token_kind_t'(4'(TK_TRUE) + 4'(word_reg));
                        mode_next  = MODE_IDLE;
                        index_next = 3'd0;
                    end else begin
                        index_next = idx_plus1;
                    end
                end else begin
                    r0_valid  = 1'b1;
                    r0.kind   = TK_ERROR;
                    mode_next = MODE_ERROR;
                end
            end
            MODE_NUMBER: begin
                if (is_num) begin
                    mag_next     = take_mag;
                    neg_next     = take_neg;
                    frozen_next  = take_frozen;
                    started_next = 1'b1;
                end else begin
                    r0_valid        = 1'b1;
                    r0.kind         = TK_NUMBER;
                    r0.number_value = 32'(num_result);
                    r0.last         = !idle_hit;
                    r1_valid        = idle_hit;
                    r1.kind         = idle_kind;
                    mode_next       = idle_mode;
                    if (idle_lit) begin
                        word_next  = idle_word;
                        index_next = 3'd1;
                    end
                end
            end
            default: begin
                r0_valid  = 1'b1;
                r0.kind   = TK_ERROR;
                mode_next = MODE_ERROR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            word_reg    <= WORD_TRUE;
            index_reg   <= 3'd0;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            frozen_reg  <= 1'b0;
            started_reg <= 1'b0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            word_reg    <= word_next;
            index_reg   <= index_next;
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            frozen_reg  <= frozen_next;
            started_reg <= started_next;
        end
    end

    jts_result_fifo u_result_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push0        (accept && r0_valid),
        .push0_data   (r0),
        .push1        (accept && r1_valid),
        .push1_data   (r1),
        .pop          (m_tready),
        .not_empty    (m_tvalid),
        .room_for_two (room_for_two),
        .head         (head)
    );

    assign m_tdata = {(TdataWidth-44)'(0), head.number_value, head.char_value, head.kind};
    assign m_tlast = head.last;

endmodule

// File: src/jts_result_fifo.sv
// Small result queue of the JSON token scanner: takes up to two results per cycle
// and hands out one per cycle while it is not empty and popped. Depends on jts_pkg.
module jts_result_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push0,
    input  jts_pkg::jts_result_t push0_data,
    input  logic                push1,
    input  jts_pkg::jts_result_t push1_data,
    input  logic                pop,
    output logic                not_empty,
    output logic                room_for_two,
    output jts_pkg::jts_result_t head
);
    import jts_pkg::*;

    jts_result_t               entry_reg [QueueDepth];
    logic [QueuePtrW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QueuePtrW:0]        count_reg, count_next;
    logic [QueuePtrW-1:0]      wr_ptr_plus1;
    logic                      do_pop;

    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= (QueuePtrW+1)'(QueueDepth - 2));
    assign head         = entry_reg[rd_ptr_reg];
    assign do_pop       = pop && not_empty;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push0 && push1) begin
            wr_ptr_next = wr_ptr_reg + (QueuePtrW)'(2);
        end else if (push0) begin
            wr_ptr_next = wr_ptr_plus1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (QueuePtrW+1)'(push0) + (QueuePtrW+1)'(push1)
                   - (QueuePtrW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            entry_reg[wr_ptr_reg] <= push0_data;
        end
        if (push1) begin
            entry_reg[wr_ptr_plus1] <= push1_data;
        end
    end

endmodule
